/* design/afhp_pkg.sv */
// ----------------------------------------------------------------------------
// afhp_pkg
// Shared types and constants for the audio file header parser.
// ----------------------------------------------------------------------------
package afhp_pkg;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_LEAD      = 4'd1,
    PH_ID3       = 4'd2,
    PH_RIFF      = 4'd3,
    PH_HDR       = 4'd4,
    PH_HDR_FMT   = 4'd5,
    PH_HDR_DATA  = 4'd6,
    PH_HDR_OTHER = 4'd7,
    PH_BODY_FMT  = 4'd8,
    PH_BODY_SKIP = 4'd9,
    PH_DONE      = 4'd10
  } afhp_phase_t;

  // container kind codes
  localparam logic [2:0] K_PLAIN     = 3'd0;
  localparam logic [2:0] K_ID3       = 3'd1;
  localparam logic [2:0] K_WAV       = 3'd2;
  localparam logic [2:0] K_NOT_WAVE  = 3'd3;
  localparam logic [2:0] K_NO_FMT    = 3'd4;
  localparam logic [2:0] K_BAD_SIZE  = 3'd5;
  localparam logic [2:0] K_TRUNC     = 3'd6;
  localparam logic [2:0] K_SHORT_FMT = 3'd7;

  // tags as little-endian words
  localparam logic [23:0] WORD_ID3  = 24'h334449;
  localparam logic [31:0] WORD_RIFF = 32'h46464952;
  localparam logic [31:0] WORD_WAVE = 32'h45564157;
  localparam logic [31:0] WORD_FMT  = 32'h20746D66;
  localparam logic [31:0] WORD_DATA = 32'h61746164;

  localparam logic [31:0] FIRST_CHUNK    = 32'd12;
  localparam logic [31:0] ID3_HEADER_LEN = 32'd10;
  localparam logic [31:0] MIN_FMT_LEN    = 32'd16;

  // one input byte with its markers
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } afhp_item_t;

  // one result
  typedef struct packed {
    logic [2:0]  container_kind;
    logic [31:0] data_offset;
    logic        is_integer_pcm;
    logic [7:0]  channel_count;
    logic [31:0] sample_rate;
    logic [7:0]  sample_bits;
  } afhp_result_t;

endpackage

/* design/afhp_in_if.sv */
// ----------------------------------------------------------------------------
// afhp_in_if
// Input byte channel: valid/ready handshake with one file byte per transaction.
// ----------------------------------------------------------------------------
interface afhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
  modport sink   (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

/* design/afhp_out_if.sv */
// ----------------------------------------------------------------------------
// afhp_out_if
// Result channel: valid/ready handshake with one header summary per transaction.
// ----------------------------------------------------------------------------
interface afhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  container_kind;
  logic [31:0] data_offset;
  logic        is_integer_pcm;
  logic [7:0]  channel_count;
  logic [31:0] sample_rate;
  logic [7:0]  sample_bits;

  modport source (output valid, container_kind, data_offset, is_integer_pcm,
                  channel_count, sample_rate, sample_bits, input ready);
  modport sink   (input valid, container_kind, data_offset, is_integer_pcm,
                  channel_count, sample_rate, sample_bits, output ready);
endinterface

/* design/afhp_in_stage.sv */
// ----------------------------------------------------------------------------
// afhp_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module afhp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  afhp_pkg::afhp_item_t in_item,
  input  logic                advance,
  output logic                item_valid,
  output afhp_pkg::afhp_item_t item
);

  logic                 valid_r;
  logic                 valid_nxt;
  afhp_pkg::afhp_item_t item_r;

  // free when empty or when the held byte moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/afhp_parse.sv */
// ----------------------------------------------------------------------------
// afhp_parse
// Header parse state machine: one byte per step, gives at most one result
// per file.
// ----------------------------------------------------------------------------
module afhp_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  afhp_pkg::afhp_item_t  item,
  output logic                  res_valid,
  output afhp_pkg::afhp_result_t res
);

  afhp_pkg::afhp_phase_t phase_r, phase_nxt, cur_phase;
  logic [31:0] pos_r, pos_nxt, cur_pos;
  logic [31:0] cs_r, cs_nxt, cur_cs;
  logic [31:0] ce_r, ce_nxt, cur_ce;
  logic [31:0] fs_r, fs_nxt, cur_fs;
  logic        fmt_seen_r, fmt_seen_nxt, cur_fmt_seen;
  logic        pcm_r, pcm_nxt, cur_pcm;
  logic [7:0]  chan_r, chan_nxt, cur_chan;
  logic [31:0] rate_r, rate_nxt, cur_rate;
  logic [7:0]  bits_r, bits_nxt, cur_bits;

  logic        sof;
  logic        active;
  logic [31:0] fs_new;
  logic [31:0] rel;
  logic [31:0] pos_inc;
  logic [27:0] syncsafe;
  logic        emit;
  logic [2:0]  kind;
  logic [31:0] offset;

  assign sof = item.start_of_file;

  // start of file restarts everything from the reset view, but in the lead phase
  assign cur_phase    = sof ? afhp_pkg::PH_LEAD : phase_r;
  assign cur_pos      = sof ? 32'd0 : pos_r;
  assign cur_cs       = sof ? afhp_pkg::FIRST_CHUNK : cs_r;
  assign cur_ce       = sof ? 32'd0 : ce_r;
  assign cur_fs       = sof ? 32'd0 : fs_r;
  assign cur_fmt_seen = sof ? 1'b0 : fmt_seen_r;
  assign cur_pcm      = sof ? 1'b0 : pcm_r;
  assign cur_chan     = sof ? 8'd0 : chan_r;
  assign cur_rate     = sof ? 32'd0 : rate_r;
  assign cur_bits     = sof ? 8'd0 : bits_r;

  // shifted word, offsets
  assign fs_new   = {item.data_byte, cur_fs[31:8]};
  assign rel      = cur_pos - cur_cs;
  assign pos_inc  = cur_pos + 32'd1;
  assign syncsafe = {fs_new[6:0], fs_new[14:8], fs_new[22:16], fs_new[30:24]};
  assign active   = step && (cur_phase != afhp_pkg::PH_IDLE)
                         && (cur_phase != afhp_pkg::PH_DONE);

  // next state and result
  always_comb begin
    phase_nxt    = cur_phase;
    pos_nxt      = cur_pos;
    cs_nxt       = cur_cs;
    ce_nxt       = cur_ce;
    fs_nxt       = cur_fs;
    fmt_seen_nxt = cur_fmt_seen;
    pcm_nxt      = cur_pcm;
    chan_nxt     = cur_chan;
    rate_nxt     = cur_rate;
    bits_nxt     = cur_bits;
    emit         = 1'b0;
    kind         = afhp_pkg::K_PLAIN;
    offset       = 32'd0;
    if (active) begin
      fs_nxt  = fs_new;
      pos_nxt = pos_inc;
      unique case (cur_phase) inside
        afhp_pkg::PH_LEAD: begin
          if (cur_pos == 32'd2 && fs_new[31:8] == afhp_pkg::WORD_ID3) begin
            phase_nxt = afhp_pkg::PH_ID3;
          end else if (cur_pos >= 32'd3) begin
            if (fs_new == afhp_pkg::WORD_RIFF) begin
              phase_nxt = afhp_pkg::PH_RIFF;
            end else begin
              emit = 1'b1;
              kind = afhp_pkg::K_PLAIN;
            end
          end
        end
        afhp_pkg::PH_ID3: begin
          if (cur_pos == 32'd9) begin
            emit   = 1'b1;
            kind   = afhp_pkg::K_ID3;
            offset = {4'd0, syncsafe} + afhp_pkg::ID3_HEADER_LEN;
          end
        end
        afhp_pkg::PH_RIFF: begin
          if (cur_pos == 32'd11) begin
            if (fs_new != afhp_pkg::WORD_WAVE) begin
              emit = 1'b1;
              kind = afhp_pkg::K_NOT_WAVE;
            end else begin
              cs_nxt    = afhp_pkg::FIRST_CHUNK;
              phase_nxt = afhp_pkg::PH_HDR;
            end
          end
        end
        afhp_pkg::PH_HDR: begin
          if (rel == 32'd3) begin
            if (fs_new == afhp_pkg::WORD_FMT) begin
              phase_nxt = afhp_pkg::PH_HDR_FMT;
            end else if (fs_new == afhp_pkg::WORD_DATA) begin
              phase_nxt = afhp_pkg::PH_HDR_DATA;
            end else begin
              phase_nxt = afhp_pkg::PH_HDR_OTHER;
            end
          end
        end
        afhp_pkg::PH_HDR_FMT, afhp_pkg::PH_HDR_DATA, afhp_pkg::PH_HDR_OTHER: begin
          if (rel == 32'd7) begin
            // body ends where the next header begins: chunk start + 8 + size
            ce_nxt = pos_inc + fs_new;
            if (cur_phase == afhp_pkg::PH_HDR_FMT) begin
              if (fs_new < afhp_pkg::MIN_FMT_LEN) begin
                emit = 1'b1;
                kind = afhp_pkg::K_SHORT_FMT;
              end else begin
                fmt_seen_nxt = 1'b1;
                phase_nxt    = afhp_pkg::PH_BODY_FMT;
              end
            end else if (cur_phase == afhp_pkg::PH_HDR_DATA) begin
              emit = 1'b1;
              if (!cur_fmt_seen) begin
                kind = afhp_pkg::K_NO_FMT;
              end else if (fs_new == 32'hFFFF_FFFF) begin
                kind = afhp_pkg::K_BAD_SIZE;
              end else begin
                kind   = afhp_pkg::K_WAV;
                offset = pos_inc;
              end
            end else begin
              phase_nxt = afhp_pkg::PH_BODY_SKIP;
            end
          end
        end
        afhp_pkg::PH_BODY_FMT, afhp_pkg::PH_BODY_SKIP: begin
          if (cur_pos == cur_ce) begin
            // this byte opens the next chunk header
            cs_nxt    = cur_pos;
            phase_nxt = afhp_pkg::PH_HDR;
          end else if (cur_phase == afhp_pkg::PH_BODY_FMT) begin
            if (rel == 32'd9) begin
              pcm_nxt = (fs_new[31:16] == 16'd1);
            end else if (rel == 32'd10) begin
              chan_nxt = item.data_byte;
            end else if (rel == 32'd15) begin
              rate_nxt = fs_new;
            end else if (rel == 32'd22) begin
              bits_nxt = item.data_byte;
            end
          end
        end
        default: begin
        end
      endcase
      // last byte without a result
      if (!emit && item.end_of_file) begin
        emit   = 1'b1;
        kind   = afhp_pkg::K_TRUNC;
        offset = 32'd0;
      end
      if (emit) begin
        phase_nxt = afhp_pkg::PH_DONE;
      end
    end
  end

  // result payload, format fields only for a wave result
  always_comb begin
    res_valid          = emit;
    res.container_kind = kind;
    res.data_offset    = offset;
    res.is_integer_pcm = (kind == afhp_pkg::K_WAV) ? cur_pcm : 1'b0;
    res.channel_count  = (kind == afhp_pkg::K_WAV) ? cur_chan : 8'd0;
    res.sample_rate    = (kind == afhp_pkg::K_WAV) ? cur_rate : 32'd0;
    res.sample_bits    = (kind == afhp_pkg::K_WAV) ? cur_bits : 8'd0;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= afhp_pkg::PH_IDLE;
      pos_r      <= 32'd0;
      cs_r       <= afhp_pkg::FIRST_CHUNK;
      ce_r       <= 32'd0;
      fs_r       <= 32'd0;
      fmt_seen_r <= 1'b0;
      pcm_r      <= 1'b0;
      chan_r     <= 8'd0;
      rate_r     <= 32'd0;
      bits_r     <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      cs_r       <= cs_nxt;
      ce_r       <= ce_nxt;
      fs_r       <= fs_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      pcm_r      <= pcm_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
    end
  end

endmodule

/* design/afhp_out_stage.sv */
// ----------------------------------------------------------------------------
// afhp_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module afhp_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_load,
  input  afhp_pkg::afhp_result_t res,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output afhp_pkg::afhp_result_t out_res
);

  logic                   valid_r;
  logic                   valid_nxt;
  afhp_pkg::afhp_result_t res_r;

  // slot can be refilled when empty or drained this cycle
  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule

/* design/audio_file_header_parser.sv */
// ----------------------------------------------------------------------------
// audio_file_header_parser
// Finds the container kind and audio payload offset of an ID3 tagged, RIFF
// wave or plain mp3 file from its leading bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one file byte per transaction; start_of_file marks byte 0
//   and restarts the parse, end_of_file marks the last byte. Bytes before
//   the first start are dropped, as are bytes after a file's result.
//   out_ch carries at most one result per file: kind, payload offset and,
//   for a wave file, the captured fmt fields.
//   Throughput is one byte per cycle while results keep being taken. A byte
//   is held in the input register and parsed there; its result is loaded
//   into the result register, which raises out_ch.valid, once the result
//   slot is free, and the receiver takes it with out_ch.ready.
//   When the receiver stalls with a result pending, the parser holds the
//   next byte in the input register and in_ch.ready drops once that
//   register is occupied; nothing is lost.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to waiting for a start of file.
// ----------------------------------------------------------------------------
module audio_file_header_parser (
  input logic      clk,
  input logic      rst_n,
  afhp_in_if.sink   in_ch,
  afhp_out_if.source out_ch
);

  afhp_pkg::afhp_item_t   in_item;
  afhp_pkg::afhp_item_t   item;
  afhp_pkg::afhp_result_t res;
  afhp_pkg::afhp_result_t out_res;
  logic                   item_valid;
  logic                   slot_free;
  logic                   advance;
  logic                   res_valid;

  assign in_item.data_byte     = in_ch.data_byte;
  assign in_item.start_of_file = in_ch.start_of_file;
  assign in_item.end_of_file   = in_ch.end_of_file;

  // a byte is parsed when the result slot can take whatever it produces
  assign advance = item_valid && slot_free;

  afhp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  afhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  afhp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.container_kind = out_res.container_kind;
  assign out_ch.data_offset    = out_res.data_offset;
  assign out_ch.is_integer_pcm = out_res.is_integer_pcm;
  assign out_ch.channel_count  = out_res.channel_count;
  assign out_ch.sample_rate    = out_res.sample_rate;
  assign out_ch.sample_bits    = out_res.sample_bits;

endmodule

/* sim/afhp_header_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afhp_header_checker
// Watches the byte and result channels of the header parser. It tracks the
// parse of every accepted byte in its own copy of the parser state, queues
// the header summary each file should give and compares every returned
// result with the oldest queued summary, field by field.
// ----------------------------------------------------------------------------
module afhp_header_checker (
  input  logic clk,
  input  logic rst_n,
  afhp_in_if   in_ch,
  afhp_out_if  out_ch,
  output int   mismatch_count,
  output int   headers_pending
);

  // byte positions within the file lead and within a chunk
  localparam logic [31:0] LEAD_TAG3_LAST = 32'd2;
  localparam logic [31:0] LEAD_TAG4_LAST = 32'd3;
  localparam logic [31:0] ID3_SIZE_LAST  = 32'd9;
  localparam logic [31:0] WAVE_LAST      = 32'd11;
  localparam logic [31:0] TAG_LAST       = 32'd3;
  localparam logic [31:0] SIZE_LAST      = 32'd7;
  localparam logic [31:0] CHUNK_HDR_LEN  = 32'd8;
  localparam logic [31:0] FMT_CODE_LAST  = 32'd9;
  localparam logic [31:0] FMT_CHANNELS   = 32'd10;
  localparam logic [31:0] FMT_RATE_LAST  = 32'd15;
  localparam logic [31:0] FMT_BITS       = 32'd22;

  // parse state of the file in flight
  afhp_pkg::afhp_phase_t phase = afhp_pkg::PH_IDLE;
  logic [31:0]  byte_pos = '0;
  logic [31:0]  chunk_base = afhp_pkg::FIRST_CHUNK;
  logic [31:0]  chunk_len = '0;
  logic [31:0]  last_word = '0;
  logic         fmt_seen = 1'b0;
  logic         held_pcm = 1'b0;
  logic [7:0]   held_channels = '0;
  logic [31:0]  held_rate = '0;
  logic [7:0]   held_bits = '0;

  afhp_pkg::afhp_result_t expected_headers[$];
  int           results_seen = 0;

  initial begin
    mismatch_count = 0;
    headers_pending = 0;
  end

  function automatic void clear_parse();
    phase = afhp_pkg::PH_IDLE;
    byte_pos = '0;
    chunk_base = afhp_pkg::FIRST_CHUNK;
    chunk_len = '0;
    last_word = '0;
    fmt_seen = 1'b0;
    held_pcm = 1'b0;
    held_channels = '0;
    held_rate = '0;
    held_bits = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // advance the parse by one byte and queue the summary it gives, if any
  task automatic predict_header(input logic [7:0] data_byte, input logic sof,
                                input logic eof);
    logic [31:0]  pos;
    logic [31:0]  rel;
    logic [27:0]  tag_size;
    logic         done;
    afhp_pkg::afhp_result_t res;
    done = 1'b0;
    res = '0;
    if (sof) begin
      clear_parse();
      phase = afhp_pkg::PH_LEAD;
    end
    if (phase == afhp_pkg::PH_IDLE || phase == afhp_pkg::PH_DONE)
      return;
    last_word = {data_byte, last_word[31:8]};
    pos = byte_pos;
    rel = pos - chunk_base;
    case (phase) inside
      afhp_pkg::PH_LEAD: begin
        if (pos == LEAD_TAG3_LAST && last_word[31:8] == afhp_pkg::WORD_ID3) begin
          phase = afhp_pkg::PH_ID3;
        end else if (pos >= LEAD_TAG4_LAST) begin
          if (last_word == afhp_pkg::WORD_RIFF) begin
            phase = afhp_pkg::PH_RIFF;
          end else begin
            done = 1'b1;
            res.container_kind = afhp_pkg::K_PLAIN;
          end
        end
      end
      afhp_pkg::PH_ID3: begin
        if (pos == ID3_SIZE_LAST) begin
          // syncsafe size, first byte most significant
          tag_size = {last_word[6:0], last_word[14:8], last_word[22:16],
                      last_word[30:24]};
          done = 1'b1;
          res.container_kind = afhp_pkg::K_ID3;
          res.data_offset = {4'h0, tag_size} + afhp_pkg::ID3_HEADER_LEN;
        end
      end
      afhp_pkg::PH_RIFF: begin
        if (pos == WAVE_LAST) begin
          if (last_word != afhp_pkg::WORD_WAVE) begin
            done = 1'b1;
            res.container_kind = afhp_pkg::K_NOT_WAVE;
          end else begin
            chunk_base = afhp_pkg::FIRST_CHUNK;
            phase = afhp_pkg::PH_HDR;
          end
        end
      end
      afhp_pkg::PH_HDR: begin
        if (rel == TAG_LAST) begin
          if (last_word == afhp_pkg::WORD_FMT)
            phase = afhp_pkg::PH_HDR_FMT;
          else if (last_word == afhp_pkg::WORD_DATA)
            phase = afhp_pkg::PH_HDR_DATA;
          else
            phase = afhp_pkg::PH_HDR_OTHER;
        end
      end
      afhp_pkg::PH_HDR_FMT, afhp_pkg::PH_HDR_DATA, afhp_pkg::PH_HDR_OTHER: begin
        if (rel == SIZE_LAST) begin
          chunk_len = last_word;
          if (phase == afhp_pkg::PH_HDR_FMT) begin
            if (chunk_len < afhp_pkg::MIN_FMT_LEN) begin
              done = 1'b1;
              res.container_kind = afhp_pkg::K_SHORT_FMT;
            end else begin
              fmt_seen = 1'b1;
              phase = afhp_pkg::PH_BODY_FMT;
            end
          end else if (phase == afhp_pkg::PH_HDR_DATA) begin
            done = 1'b1;
            if (!fmt_seen) begin
              res.container_kind = afhp_pkg::K_NO_FMT;
            end else if (chunk_len == '1) begin
              res.container_kind = afhp_pkg::K_BAD_SIZE;
            end else begin
              res.container_kind = afhp_pkg::K_WAV;
              res.data_offset = chunk_base + CHUNK_HDR_LEN;
              res.is_integer_pcm = held_pcm;
              res.channel_count = held_channels;
              res.sample_rate = held_rate;
              res.sample_bits = held_bits;
            end
          end else begin
            phase = afhp_pkg::PH_BODY_SKIP;
          end
        end
      end
      afhp_pkg::PH_BODY_FMT, afhp_pkg::PH_BODY_SKIP: begin
        // chunk end found by equality, sum wraps at 32 bits
        if (rel == CHUNK_HDR_LEN + chunk_len) begin
          chunk_base = pos;
          phase = afhp_pkg::PH_HDR;
        end else if (phase == afhp_pkg::PH_BODY_FMT) begin
          case (rel)
            FMT_CODE_LAST: held_pcm = (last_word[31:16] == 16'd1);
            FMT_CHANNELS:  held_channels = data_byte;
            FMT_RATE_LAST: held_rate = last_word;
            FMT_BITS:      held_bits = data_byte;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    byte_pos = pos + 32'd1;
    // end of file with nothing decided yet
    if (!done && eof) begin
      done = 1'b1;
      res.container_kind = afhp_pkg::K_TRUNC;
    end
    if (done) begin
      phase = afhp_pkg::PH_DONE;
      expected_headers.push_back(res);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
  endtask

  // compare one result transaction with the oldest summary
  task automatic check_result();
    afhp_pkg::afhp_result_t want;
    if (expected_headers.size() == 0) begin
      report_mismatch($sformatf("result %0d with none expected: kind %0d offset 0x%0h",
                                results_seen, out_ch.container_kind, out_ch.data_offset));
    end else begin
      want = expected_headers.pop_front();
      compare_field("container_kind", 32'(out_ch.container_kind),
                    32'(want.container_kind));
      compare_field("data_offset", out_ch.data_offset, want.data_offset);
      compare_field("is_integer_pcm", 32'(out_ch.is_integer_pcm),
                    32'(want.is_integer_pcm));
      compare_field("channel_count", 32'(out_ch.channel_count),
                    32'(want.channel_count));
      compare_field("sample_rate", out_ch.sample_rate, want.sample_rate);
      compare_field("sample_bits", 32'(out_ch.sample_bits), 32'(want.sample_bits));
    end
    results_seen++;
  endtask

  // sample both channels at every edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_headers.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_header(in_ch.data_byte, in_ch.start_of_file, in_ch.end_of_file);
      if (out_ch.valid && out_ch.ready)
        check_result();
    end
    headers_pending <= expected_headers.size();
  end

endmodule

/* sim/tb_audio_file_header_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_file_header_parser
// Feeds the header parser with ID3, RIFF wave, plain and malformed files,
// first a directed set of edge cases and then random files, with random
// gaps on the byte side and random stalls on the result side. Results are
// checked by afhp_header_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_audio_file_header_parser;

  localparam int BYTE_BUDGET   = 2000;
  localparam int MIN_FILES     = 60;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 20;

  // chunk tags that are neither fmt nor data
  localparam logic [31:0] WORD_JUNK = 32'h4B4E554A;
  localparam logic [31:0] WORD_LIST = 32'h5453494C;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   headers_pending;
  logic hold_request;
  bit   sender_calm;
  int   bytes_sent;
  int   files_sent;
  logic [7:0] file_buf[$];

  afhp_in_if  in_ch();
  afhp_out_if out_ch();

  audio_file_header_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  afhp_header_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .headers_pending (headers_pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // file building
  function automatic void add_noise(input int count);
    for (int i = 0; i < count; i++)
      file_buf.push_back(8'($urandom));
  endfunction

  function automatic void add_half(input logic [15:0] h);
    file_buf.push_back(h[7:0]);
    file_buf.push_back(h[15:8]);
  endfunction

  function automatic void add_word(input logic [31:0] w);
    add_half(w[15:0]);
    add_half(w[31:16]);
  endfunction

  function automatic void add_riff_head();
    add_word(afhp_pkg::WORD_RIFF);
    add_word($urandom);
    add_word(afhp_pkg::WORD_WAVE);
  endfunction

  // size bytes in file order, most significant first
  function automatic void add_id3(input logic [31:0] size_raw);
    file_buf.push_back(afhp_pkg::WORD_ID3[7:0]);
    file_buf.push_back(afhp_pkg::WORD_ID3[15:8]);
    file_buf.push_back(afhp_pkg::WORD_ID3[23:16]);
    add_noise(3);
    file_buf.push_back(size_raw[31:24]);
    file_buf.push_back(size_raw[23:16]);
    file_buf.push_back(size_raw[15:8]);
    file_buf.push_back(size_raw[7:0]);
  endfunction

  function automatic void add_fmt(input logic [31:0] size, input logic [15:0] code,
                                  input logic [7:0] channels, input logic [31:0] rate,
                                  input logic [7:0] bits);
    add_word(afhp_pkg::WORD_FMT);
    add_word(size);
    if (size < afhp_pkg::MIN_FMT_LEN)
      return;
    add_half(code);
    add_half({8'($urandom), channels});
    add_word(rate);
    add_word($urandom);
    add_half(16'($urandom));
    add_half({8'($urandom), bits});
    add_noise(int'(size) - 16);
  endfunction

  function automatic void add_other(input logic [31:0] tag, input logic [31:0] size,
                                    input int body);
    add_word(tag);
    add_word(size);
    add_noise(body);
  endfunction

  function automatic void add_data(input logic [31:0] size);
    add_word(afhp_pkg::WORD_DATA);
    add_word(size);
    add_noise($urandom_range(0, 3));
  endfunction

  function automatic void add_random_other();
    logic [31:0] tag;
    int          roll;
    int          size;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: tag = WORD_JUNK;
      1: tag = WORD_LIST;
      2: tag = afhp_pkg::WORD_FMT ^ (32'd1 << $urandom_range(0, 31));
      default: tag = afhp_pkg::WORD_DATA ^ (32'd1 << $urandom_range(0, 31));
    endcase
    if (roll < 5) begin
      // a skip that never ends within the file
      add_other(tag, $urandom | 32'h8000_0000, $urandom_range(4, 12));
    end else begin
      size = $urandom_range(0, 8);
      add_other(tag, size, size);
    end
  endfunction

  function automatic void add_random_fmt();
    logic [31:0] size;
    logic [15:0] code;
    logic [31:0] rate;
    size = ($urandom_range(0, 9) != 0) ? 32'(16 + $urandom_range(0, 8))
                                       : 32'($urandom_range(0, 15));
    case ($urandom_range(0, 3)) inside
      0, 1: code = 16'd1;
      2: code = 16'd3;
      default: code = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: rate = 32'd44100;
      1: rate = 32'd48000;
      2: rate = '1;
      3: rate = '0;
      default: rate = $urandom;
    endcase
    add_fmt(size, code, 8'($urandom), rate, 8'($urandom));
  endfunction

  // mostly well formed wave files with random chunk lists
  function automatic void build_wave_file();
    logic [31:0] payload_size;
    int          roll;
    add_riff_head();
    repeat ($urandom_range(0, 2)) add_random_other();
    if ($urandom_range(0, 29) != 0) begin
      add_random_fmt();
      if ($urandom_range(0, 9) == 0) begin
        add_random_other();
        add_random_fmt();
      end
    end
    repeat ($urandom_range(0, 1)) add_random_other();
    roll = $urandom_range(0, 99);
    if (roll < 5)
      payload_size = '1;
    else if (roll < 10)
      payload_size = 32'hFFFF_FFFE;
    else
      payload_size = $urandom;
    add_data(payload_size);
  endfunction

  function automatic void build_random_file();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      build_wave_file();
    end else if (roll < 68) begin
      add_id3(($urandom_range(0, 1) != 0) ? ($urandom & 32'h7F7F_7F7F) : $urandom);
      add_noise($urandom_range(0, 4));
    end else if (roll < 78) begin
      add_noise($urandom_range(1, 8));
    end else if (roll < 86) begin
      // wave tag slightly off
      add_word(afhp_pkg::WORD_RIFF);
      add_word($urandom);
      add_word(afhp_pkg::WORD_WAVE ^ (32'd1 << $urandom_range(0, 31)));
      add_noise($urandom_range(0, 4));
    end else if (roll < 94) begin
      // lead that starts like a known tag
      if ($urandom_range(0, 1) != 0) begin
        file_buf.push_back(afhp_pkg::WORD_ID3[7:0]);
        file_buf.push_back(afhp_pkg::WORD_ID3[15:8]);
      end else begin
        file_buf.push_back(afhp_pkg::WORD_RIFF[7:0]);
        file_buf.push_back(afhp_pkg::WORD_RIFF[15:8]);
        file_buf.push_back(afhp_pkg::WORD_RIFF[23:16]);
      end
      add_noise($urandom_range(1, 6));
    end else begin
      add_noise($urandom_range(10, 30));
    end
  endfunction

  // byte side
  function automatic int pick_gap();
    int roll;
    if (sender_calm)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return 0;
    if (roll < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic sof, input logic eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= value;
    in_ch.start_of_file <= sof;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_file(input int count, input bit mark_eof);
    for (int i = 0; i < count; i++)
      send_byte(file_buf[i], i == 0, mark_eof && i == count - 1);
    file_buf.delete();
    files_sent++;
  endtask

  // bytes with no start mark, either continuing a parse or ignored
  task automatic send_stray(input int count);
    for (int i = 0; i < count; i++)
      send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_random_ending();
    if ($urandom_range(0, 4) == 0)
      send_file($urandom_range(1, file_buf.size()), 1'b1);
    else
      send_file(file_buf.size(), 1'($urandom_range(0, 1)));
  endtask

  // pause the byte side until every queued summary has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (headers_pending != 0);
  endtask

  // result side: random stalls, calm stretches and one long hold on request
  initial begin : result_sink
    int stall;
    int mode_left;
    int roll;
    bit calm;
    bit hold_taken;
    stall = 0;
    mode_left = 0;
    calm = 1'b0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (!hold_request)
        hold_taken = 1'b0;
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm) begin
        roll = $urandom_range(0, 99);
        if (roll < 20)
          stall = $urandom_range(1, 3);
        else if (roll < 24)
          stall = $urandom_range(10, 60);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    bytes_sent = 0;
    files_sent = 0;
    sender_calm = 1'b0;
    rst_n <= 1'b0;
    hold_request <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.start_of_file <= 1'b0;
    in_ch.end_of_file <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // bytes before any start are dropped, end mark too
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    // one-byte file
    file_buf.push_back(afhp_pkg::WORD_ID3[7:0]);
    send_file(1, 1'b1);
    // plain file with the end mark on the deciding byte, then ignored bytes
    add_word(32'h00FF_00FF);
    send_file(4, 1'b1);
    send_stray(3);
    // tagged files: largest size, masked high bits, zero size
    add_id3(32'h7F7F_7F7F);
    send_file(file_buf.size(), 1'b0);
    add_id3(32'hFFFF_FFFF);
    send_file(file_buf.size(), 1'b1);
    add_id3(32'h8080_8080);
    send_file(file_buf.size(), 1'b0);
    // tagged file cut inside its header
    add_id3(32'h0);
    send_file(6, 1'b1);
    // riff that is not wave
    add_word(afhp_pkg::WORD_RIFF);
    add_word('1);
    add_word(afhp_pkg::WORD_WAVE ^ 32'h8000_0000);
    send_file(file_buf.size(), 1'b0);
    // data before any fmt
    add_riff_head();
    add_data(32'd0);
    send_file(file_buf.size(), 1'b0);
    // integer pcm with all-ones fields
    add_riff_head();
    add_fmt(32'd16, 16'd1, 8'hFF, '1, 8'hFF);
    add_data(32'd0);
    send_file(file_buf.size(), 1'b1);
    // short fmt chunks
    add_riff_head();
    add_fmt(32'd15, 16'd1, 8'd2, 32'd8000, 8'd8);
    send_file(file_buf.size(), 1'b0);
    add_riff_head();
    add_fmt(32'd0, 16'd1, 8'd2, 32'd8000, 8'd8);
    send_file(file_buf.size(), 1'b0);
    // data size all ones
    add_riff_head();
    add_fmt(32'd16, 16'd3, 8'd0, 32'd0, 8'd0);
    add_data('1);
    send_file(file_buf.size(), 1'b0);
    // skipped chunks and a second fmt that overwrites the first
    add_riff_head();
    add_other(WORD_LIST, 32'd0, 0);
    add_other(WORD_JUNK, 32'd5, 5);
    add_fmt(32'd18, 16'h0101, 8'd6, 32'd96000, 8'd24);
    add_fmt(32'd16, 16'd1, 8'd2, 32'd44100, 8'd16);
    add_data(32'hFFFF_FFFE);
    send_file(file_buf.size(), 1'b1);
    // end of file inside the data header
    add_riff_head();
    add_fmt(32'd16, 16'd1, 8'd1, 32'd22050, 8'd8);
    add_data(32'd100);
    send_file(file_buf.size() - 4, 1'b1);
    // new start in the middle of a header
    add_riff_head();
    send_file(6, 1'b0);
    add_noise(4);
    file_buf[0] = 8'h00;
    send_file(4, 1'b0);
    // skip length that wraps past the end of the file
    add_riff_head();
    add_other(WORD_JUNK, 32'hFFFF_FFF4, 10);
    send_file(file_buf.size(), 1'b1);
    wait_for_results();

    // long hold on the result side while plain files keep coming
    hold_request <= 1'b1;
    sender_calm = 1'b1;
    repeat (8) begin
      add_noise(4);
      file_buf[0] = 8'hFF;
      send_file(4, 1'b0);
    end
    hold_request <= 1'b0;
    sender_calm = 1'b0;
    wait_for_results();

    // random files
    while (bytes_sent < BYTE_BUDGET || files_sent < MIN_FILES) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      build_random_file();
      send_random_ending();
      if ($urandom_range(0, 19) == 0)
        send_stray($urandom_range(1, 5));
      if ($urandom_range(0, 29) == 0)
        wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && headers_pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
